@@ hdl/vrpg_pkg.sv @@
package vrpg_pkg;

  localparam int MEM_AW = 16;
  localparam int BYTE_W = 8;

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_HIRES   = 2'd1,
    MODE_HICOLOR = 2'd2,
    MODE_LORES   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_VIDEO_MODE    = 3'd0,
    REG_ROWS_PER_CELL = 3'd1,
    REG_BITMAP_BASE   = 3'd2,
    REG_COLOR_BASE    = 3'd3,
    REG_FONT_BASE     = 3'd4
  } reg_idx_t;

  // Work kind decided in the front, carried out in the back
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_MONO   = 2'd2,
    KIND_NIBBLE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [MEM_AW-1:0]    addr;
    logic [MEM_AW-1:0]    color_addr;
    logic [BYTE_W-1:0]    wdata;
    logic [2:0]           bit_sel;
    logic [BYTE_W-1:0]    font_page;
    logic                 line_end;
    logic                 frame_end;
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_end;
  } pix_t;

  localparam logic [MEM_AW-1:0] STRIDE_LORES   = 16'd40;
  localparam logic [MEM_AW-1:0] STRIDE_TEXT    = 16'd80;
  localparam logic [MEM_AW-1:0] STRIDE_HICOLOR = 16'd160;

  localparam logic [1:0]        RST_VIDEO_MODE  = 2'd0;
  localparam logic [4:0]        RST_ROWS        = 5'd15;
  localparam logic [MEM_AW-1:0] RST_BITMAP_BASE = 16'd0;
  localparam logic [MEM_AW-1:0] RST_COLOR_BASE  = 16'd4096;
  localparam logic [7:0]        RST_FONT_BASE   = 8'd32;

  localparam logic [7:0] PAL_RED [16] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd150, 8'd150, 8'd150, 8'd150,
    8'd104, 8'd104, 8'd104, 8'd104, 8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [7:0] PAL_GREEN [16] = '{
    8'd0, 8'd0, 8'd150, 8'd150, 8'd0, 8'd0, 8'd150, 8'd150,
    8'd104, 8'd104, 8'd255, 8'd255, 8'd104, 8'd104, 8'd255, 8'd255};
  localparam logic [7:0] PAL_BLUE [16] = '{
    8'd0, 8'd150, 8'd0, 8'd150, 8'd0, 8'd150, 8'd0, 8'd150,
    8'd104, 8'd255, 8'd104, 8'd255, 8'd104, 8'd255, 8'd104, 8'd255};

endpackage

@@ hdl/vrpg_fifo.sv @@
module vrpg_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic not_empty
);

  localparam int AW = $clog2(DEPTH);

  T                mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/vrpg_front.sv @@
module vrpg_front
  import vrpg_pkg::*;
#(
  parameter int LINE_PIXELS = 640,
  parameter int FRAME_LINES = 480
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [MEM_AW-1:0] in_mem_address,
  input  logic [BYTE_W-1:0] in_mem_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output op_t               q_op
);

  localparam int COL_W  = $clog2(LINE_PIXELS);
  localparam int LINE_W = $clog2(FRAME_LINES);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [4:0]        subrow_r, subrow_nxt;
  logic [MEM_AW-1:0] row_off_r, row_off_nxt;

  mode_t             mode_r;
  logic [4:0]        rows_r;
  logic [MEM_AW-1:0] bmp_base_r;
  logic [MEM_AW-1:0] clr_base_r;
  logic [7:0]        font_base_r;

  logic              acc;
  logic              tick;
  logic              last_pixel;
  logic              last_line;
  logic [MEM_AW-1:0] cell_idx;
  logic [2:0]        sel;
  kind_t             pix_kind;
  logic [MEM_AW-1:0] stride;
  logic [MEM_AW-1:0] data_addr;
  logic [MEM_AW-1:0] color_addr;

  assign in_stall   = clearing | q_full;
  assign acc        = in_valid & ~in_stall;
  assign tick       = acc & (in_opcode == OPC_PIXEL);
  assign q_push     = acc;
  assign last_pixel = (col_r == COL_W'(LINE_PIXELS - 1));
  assign last_line  = (line_r == LINE_W'(FRAME_LINES - 1));

  // Cell index, bit within the byte, pixel kind and row stride for the current column and mode
  always_comb begin
    unique case (mode_r)
      MODE_HICOLOR: begin
        cell_idx = MEM_AW'(col_r >> 2);
        sel      = {2'b00, col_r[1]};
        pix_kind = KIND_NIBBLE;
        stride   = STRIDE_HICOLOR;
      end
      MODE_LORES: begin
        cell_idx = MEM_AW'(col_r >> 4);
        sel      = col_r[3:1];
        pix_kind = KIND_MONO;
        stride   = STRIDE_LORES;
      end
      MODE_HIRES: begin
        cell_idx = MEM_AW'(col_r >> 3);
        sel      = col_r[2:0];
        pix_kind = KIND_MONO;
        stride   = STRIDE_TEXT;
      end
      default: begin
        cell_idx = MEM_AW'(col_r >> 3);
        sel      = col_r[2:0];
        pix_kind = KIND_TEXT;
        stride   = STRIDE_TEXT;
      end
    endcase
  end

  assign data_addr  = bmp_base_r + row_off_r + cell_idx;
  assign color_addr = clr_base_r + row_off_r + cell_idx;

  always_comb begin
    q_op.kind       = (in_opcode == OPC_PIXEL) ? pix_kind : KIND_WRITE;
    q_op.addr       = (in_opcode == OPC_PIXEL) ? data_addr : in_mem_address;
    q_op.color_addr = color_addr;
    q_op.wdata      = in_mem_data;
    q_op.bit_sel    = sel;
    q_op.font_page  = font_base_r + 8'(subrow_r);
    q_op.line_end   = last_pixel;
    q_op.frame_end  = last_pixel & last_line;
  end

  always_comb begin
    col_nxt     = col_r;
    line_nxt    = line_r;
    subrow_nxt  = subrow_r;
    row_off_nxt = row_off_r;
    if (tick) begin
      if (!last_pixel) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        if (last_line) begin
          line_nxt    = '0;
          subrow_nxt  = '0;
          row_off_nxt = '0;
        end else begin
          line_nxt = line_r + LINE_W'(1);
          if (subrow_r == rows_r) begin
            subrow_nxt  = '0;
            row_off_nxt = row_off_r + stride;
          end else begin
            subrow_nxt = subrow_r + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      subrow_r    <= '0;
      row_off_r   <= '0;
      mode_r      <= mode_t'(RST_VIDEO_MODE);
      rows_r      <= RST_ROWS;
      bmp_base_r  <= RST_BITMAP_BASE;
      clr_base_r  <= RST_COLOR_BASE;
      font_base_r <= RST_FONT_BASE;
    end else begin
      col_r     <= col_nxt;
      line_r    <= line_nxt;
      subrow_r  <= subrow_nxt;
      row_off_r <= row_off_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VIDEO_MODE:    mode_r      <= mode_t'(cfg_wdata[1:0]);
          REG_ROWS_PER_CELL: rows_r      <= cfg_wdata[4:0];
          REG_BITMAP_BASE:   bmp_base_r  <= cfg_wdata;
          REG_COLOR_BASE:    clr_base_r  <= cfg_wdata;
          REG_FONT_BASE:     font_base_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(LINE_PIXELS - 1))
    else $error("pixel column past line end");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && last_pixel && last_line) |=>
      (col_r == '0 && line_r == '0 && subrow_r == '0 && row_off_r == '0))
    else $error("raster did not return to origin after frame end");
`endif

endmodule

@@ hdl/vrpg_back.sv @@
module vrpg_back
  import vrpg_pkg::*;
#(
  parameter int VIDEO_MEM_DEPTH = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        q_op,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_line_end,
  output logic       out_frame_end
);

  localparam int OUT_DEPTH = 4;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Two copies: one serves the data and color reads, the other the font read
  logic [BYTE_W-1:0] mem_a [VIDEO_MEM_DEPTH];
  logic [BYTE_W-1:0] mem_b [VIDEO_MEM_DEPTH];

  logic              clearing_r;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              is_pix;
  logic              pix_pop;
  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [BYTE_W-1:0] wdata;

  logic              s1_vld_r;
  kind_t             s1_kind_r;
  logic [2:0]        s1_sel_r;
  logic [7:0]        s1_fpage_r;
  logic              s1_le_r;
  logic              s1_fe_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] rd_color_r;

  logic              s2_vld_r;
  kind_t             s2_kind_r;
  logic [2:0]        s2_sel_r;
  logic              s2_le_r;
  logic              s2_fe_r;
  logic [BYTE_W-1:0] s2_data_r;
  logic [BYTE_W-1:0] s2_color_r;
  logic [BYTE_W-1:0] font_q_r;

  logic [BYTE_W-1:0] pat;
  logic [3:0]        idx;
  pix_t              pix;
  pix_t              head;
  logic              ofifo_full;
  logic              out_xfer;

  assign clearing = clearing_r;
  assign is_pix   = (q_op.kind != KIND_WRITE);
  // Admit a pixel only when a slot in the output buffer is reserved for it
  assign q_pop    = q_valid & ~clearing_r & (~is_pix | (cnt_r < CNT_W'(OUT_DEPTH)));
  assign pix_pop  = q_pop & is_pix;
  assign we       = clearing_r | (q_pop & ~is_pix);
  assign waddr    = clearing_r ? clr_addr_r : q_op.addr;
  assign wdata    = clearing_r ? '0 : q_op.wdata;
  assign out_xfer = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
    end
    rd_data_r  <= mem_a[q_op.addr];
    rd_color_r <= mem_a[q_op.color_addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_b[waddr] <= wdata;
    end
    font_q_r <= mem_b[{s1_fpage_r, rd_data_r}];
  end

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(pix_pop) - CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      cnt_r      <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_AW'(VIDEO_MEM_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      cnt_r    <= cnt_nxt;
      s1_vld_r <= pix_pop;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= q_op.kind;
    s1_sel_r   <= q_op.bit_sel;
    s1_fpage_r <= q_op.font_page;
    s1_le_r    <= q_op.line_end;
    s1_fe_r    <= q_op.frame_end;
    s2_kind_r  <= s1_kind_r;
    s2_sel_r   <= s1_sel_r;
    s2_le_r    <= s1_le_r;
    s2_fe_r    <= s1_fe_r;
    s2_data_r  <= rd_data_r;
    s2_color_r <= rd_color_r;
  end

  // Set bit picks the low color nibble, clear bit the high one; nibble mode takes the index from the data byte
  always_comb begin
    pat = (s2_kind_r == KIND_TEXT) ? font_q_r : s2_data_r;
    if (s2_kind_r == KIND_NIBBLE) begin
      idx = s2_sel_r[0] ? s2_data_r[7:4] : s2_data_r[3:0];
    end else begin
      idx = pat[s2_sel_r] ? s2_color_r[3:0] : s2_color_r[7:4];
    end
    pix.red       = PAL_RED[idx];
    pix.green     = PAL_GREEN[idx];
    pix.blue      = PAL_BLUE[idx];
    pix.line_end  = s2_le_r;
    pix.frame_end = s2_fe_r;
  end

  vrpg_fifo #(
    .T     (pix_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_vld_r),
    .push_data (pix),
    .full      (ofifo_full),
    .pop       (out_xfer),
    .pop_data  (head),
    .not_empty (out_valid)
  );

  assign out_red       = head.red;
  assign out_green     = head.green;
  assign out_blue      = head.blue;
  assign out_line_end  = head.line_end;
  assign out_frame_end = head.frame_end;

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(OUT_DEPTH))
    else $error("output credit count overflow");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !q_pop)
    else $error("queue popped during memory clear");

  a_buf_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> !ofifo_full)
    else $error("pixel reached a full output buffer");
`endif

endmodule

@@ hdl/video_raster_pixel_generator.sv @@
// Pixels pass through the input queue, the memory read stage, the font read stage and the output buffer.
// Memory writes produce no output and retire when the back end pops them from the queue.
// Throughput: one item per cycle when not stalled, set by the back end retiring one queue entry per cycle.
// Reset (rst_n low, synchronous): raster counters and registers return to defaults,
// then video memory is zeroed one byte per cycle, all VIDEO_MEM_DEPTH bytes, with in_stall high;
// configuration writes are taken throughout.
module video_raster_pixel_generator
  import vrpg_pkg::*;
#(
  parameter int LINE_PIXELS     = 640,
  parameter int FRAME_LINES     = 480,
  parameter int VIDEO_MEM_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [MEM_AW-1:0] in_mem_address,
  input  logic [BYTE_W-1:0] in_mem_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_line_end,
  output logic              out_frame_end,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  logic clearing;
  logic q_full;
  logic q_push;
  op_t  q_in_op;
  logic q_valid;
  logic q_pop;
  op_t  q_head;

  vrpg_front #(
    .LINE_PIXELS (LINE_PIXELS),
    .FRAME_LINES (FRAME_LINES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_mem_address (in_mem_address),
    .in_mem_data    (in_mem_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (q_in_op)
  );

  vrpg_fifo #(
    .T     (op_t),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .not_empty (q_valid)
  );

  vrpg_back #(
    .VIDEO_MEM_DEPTH (VIDEO_MEM_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ bench/tb_video_raster_pixel_generator.sv @@
module tb_video_raster_pixel_generator;
  import vrpg_pkg::*;

  localparam int LINE_PIXELS    = 640;
  localparam int FRAME_LINES    = 480;
  localparam int SETTLE_CYCLES  = 16;
  // covers the memory clear after reset several times over
  localparam int WATCHDOG_LIMIT = 262144;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic              opcode;
    logic [MEM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } vram_cmd_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_opcode      = OPC_WRITE;
  logic [MEM_AW-1:0] in_mem_address = '0;
  logic [BYTE_W-1:0] in_mem_data    = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              out_line_end;
  logic              out_frame_end;
  logic              cfg_we         = 1'b0;
  logic [2:0]        cfg_index      = '0;
  logic [15:0]       cfg_wdata      = '0;

  // shadow copy of video memory, the raster state and registers
  logic [7:0]  vram_shadow [65536];
  logic [9:0]  px_col;
  logic [8:0]  scan_line;
  logic [4:0]  sub_row;
  logic [15:0] row_base;
  mode_t       mode_r;
  logic [4:0]  rows_m1_r;
  logic [15:0] bitmap_base_r;
  logic [15:0] color_base_r;
  logic [7:0]  font_base_r;

  vram_cmd_t cmd_q[$];
  pix_t      pixel_expect_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cmds_issued    = 0;
  int cmds_accepted  = 0;
  int writes_done    = 0;
  int pixels_seen    = 0;
  int lines_seen     = 0;
  int frames_seen    = 0;
  int errors         = 0;
  int idle_cycles    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  video_raster_pixel_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_mem_address(in_mem_address),
    .in_mem_data   (in_mem_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // palette channel: two index bits pick one of four intensities
  function automatic logic [7:0] intensity(logic [1:0] code);
    case (code)
      2'd0: return 8'd0;
      2'd1: return 8'd150;
      2'd2: return 8'd104;
      default: return 8'd255;
    endcase
  endfunction

  // apply one transfer to the shadow state, queue the pixel it yields
  function automatic void raster_step(vram_cmd_t cmd);
    logic [15:0] cell_col;
    logic [15:0] data_addr;
    logic [15:0] attr_addr;
    logic [2:0]  bit_pos;
    logic [7:0]  pattern;
    logic [7:0]  attr;
    logic [7:0]  font_page;
    logic [3:0]  idx;
    logic        last_px;
    logic        last_ln;
    pix_t        px;
    if (cmd.opcode == OPC_WRITE) begin
      vram_shadow[cmd.addr] = cmd.data;
      return;
    end
    bit_pos = px_col[2:0];
    if (mode_r == MODE_LORES) begin
      cell_col = 16'(px_col >> 4);
      bit_pos  = px_col[3:1];
    end else if (mode_r == MODE_HICOLOR) begin
      cell_col = 16'(px_col >> 2);
    end else begin
      cell_col = 16'(px_col >> 3);
    end
    data_addr = bitmap_base_r + row_base + cell_col;
    attr_addr = color_base_r + row_base + cell_col;
    pattern   = vram_shadow[data_addr];
    attr      = vram_shadow[attr_addr];
    if (mode_r == MODE_TEXT) begin
      font_page = font_base_r + 8'(sub_row);
      pattern   = vram_shadow[{font_page, pattern}];
    end
    if (mode_r == MODE_HICOLOR) begin
      idx = px_col[1] ? pattern[7:4] : pattern[3:0];
    end else begin
      idx = pattern[bit_pos] ? attr[3:0] : attr[7:4];
    end
    last_px      = (px_col == LINE_PIXELS - 1);
    last_ln      = (scan_line == FRAME_LINES - 1);
    px.red       = intensity({idx[3], idx[2]});
    px.green     = intensity({idx[3], idx[1]});
    px.blue      = intensity({idx[3], idx[0]});
    px.line_end  = last_px;
    px.frame_end = last_px && last_ln;
    pixel_expect_q.push_back(px);

    if (!last_px) begin
      px_col++;
    end else begin
      px_col = '0;
      if (last_ln) begin
        scan_line = '0;
        sub_row   = '0;
        row_base  = '0;
      end else begin
        scan_line++;
        if (sub_row == rows_m1_r) begin
          sub_row  = '0;
          row_base += (mode_r == MODE_HICOLOR) ? 16'd160 :
                      (mode_r == MODE_LORES) ? 16'd40 : 16'd80;
        end else begin
          sub_row++;
        end
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: pixel %0d %s expected %0d got %0d", $time, pixels_seen, name, want, got);
      end
    end
  endfunction

  // command driver
  always @(posedge clk) begin : drive_cmds
    vram_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        raster_step({in_opcode, in_mem_address, in_mem_data});
        if (in_opcode == OPC_WRITE) writes_done++;
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd = cmd_q.pop_front();
          in_valid       <= 1'b1;
          in_opcode      <= cmd.opcode;
          in_mem_address <= cmd.addr;
          in_mem_data    <= cmd.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin : check_pixels
    pix_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (out_line_end === 1'b1) lines_seen++;
        if (out_frame_end === 1'b1) frames_seen++;
        if (pixel_expect_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: pixel transfer with nothing expected, expected none got rgb %0d/%0d/%0d",
                     $time, out_red, out_green, out_blue);
          end
        end else begin
          want = pixel_expect_q.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("line_end", 8'(want.line_end), 8'(out_line_end));
          check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(logic opc, logic [15:0] addr, logic [7:0] data);
    cmd_q.push_back({opc, addr, data});
    cmds_issued++;
  endtask

  task automatic fill_random(logic [15:0] base, int len);
    for (int i = 0; i < len; i++) begin
      push_cmd(OPC_WRITE, base + 16'(i), 8'($urandom));
    end
  endtask

  // queue the given number of pixels, with writes mixed in, mostly near the live fetch window
  task automatic push_mixed(int pixels, int write_pct);
    logic [15:0] addr;
    int          left;
    left = pixels;
    while (left > 0) begin
      if ($urandom_range(99) < write_pct) begin
        case ($urandom_range(3))
          0: addr = 16'($urandom);
          1: addr = bitmap_base_r + row_base + 16'($urandom_range(159));
          2: addr = color_base_r + row_base + 16'($urandom_range(79));
          default: addr = {font_base_r + 8'(sub_row) + 8'($urandom_range(1)), 8'($urandom)};
        endcase
        push_cmd(OPC_WRITE, addr, 8'($urandom));
      end else begin
        push_cmd(OPC_PIXEL, 16'($urandom), 8'($urandom));
        left--;
      end
    end
  endtask

  // wait until every command is taken and every pixel is back, then let writes retire
  task automatic drain();
    do @(posedge clk);
    while (cmds_accepted != cmds_issued || pixel_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VIDEO_MODE:    mode_r = mode_t'(val[1:0]);
      REG_ROWS_PER_CELL: rows_m1_r = val[4:0];
      REG_BITMAP_BASE:   bitmap_base_r = val;
      REG_COLOR_BASE:    color_base_r = val;
      REG_FONT_BASE:     font_base_r = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin : stimulus
    mode_t m;
    foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
    px_col        = '0;
    scan_line     = '0;
    sub_row       = '0;
    row_base      = '0;
    mode_r        = MODE_TEXT;
    rows_m1_r     = 5'd15;
    bitmap_base_r = 16'h0000;
    color_base_r  = 16'h1000;
    font_base_r   = 8'h20;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers, text mode: two characters with both color nibbles in use
    push_cmd(OPC_WRITE, 16'h0000, 8'h41);
    push_cmd(OPC_WRITE, 16'h1000, 8'h2E);
    push_cmd(OPC_WRITE, 16'h2041, 8'hA5);
    push_cmd(OPC_WRITE, 16'h0001, 8'hFF);
    push_cmd(OPC_WRITE, 16'h1001, 8'hF0);
    push_cmd(OPC_WRITE, 16'h20FF, 8'h81);
    push_cmd(OPC_WRITE, 16'hFFFF, 8'hFF);
    push_mixed(16, 0);
    drain();

    // populate the fetch windows
    cfg_write(REG_BITMAP_BASE, 16'h0000);
    cfg_write(REG_COLOR_BASE, 16'h2000);
    cfg_write(REG_FONT_BASE, 16'h0040);
    fill_random(16'h0000, 48);
    fill_random(16'h2000, 48);
    fill_random(16'h4000, 48);
    drain();

    // bases at the top of memory so fetches wrap around
    cfg_write(REG_BITMAP_BASE, 16'hFFFF);
    cfg_write(REG_COLOR_BASE, 16'hFFC0);
    cfg_write(REG_FONT_BASE, 16'h00FF);
    push_mixed(24, 10);
    drain();

    // one cell row per scanline so the line turn advances the row offset
    cfg_write(REG_BITMAP_BASE, 16'h0000);
    cfg_write(REG_COLOR_BASE, 16'h2000);
    cfg_write(REG_FONT_BASE, 16'h0040);
    cfg_write(REG_ROWS_PER_CELL, 16'd0);

    // each mode under its own handshake pressure profile; the last one runs through a line end
    m = m.first();
    for (int p = 0; p < 4; p++) begin
      cfg_write(REG_VIDEO_MODE, 16'(m));
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      push_mixed(160, 15);
      drain();
      m = m.next();
    end

    $display("Covered %0d pixels with %0d line ends and %0d frame ends, plus %0d memory writes,",
             pixels_seen, lines_seen, frames_seen, writes_done);
    $display("across all display modes, wrapped fetch addresses and stalls on either side");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vrpg_pkg.sv
hdl/vrpg_fifo.sv
hdl/vrpg_front.sv
hdl/vrpg_back.sv
hdl/video_raster_pixel_generator.sv
bench/tb_video_raster_pixel_generator.sv
